[rtl/bpi_pkg.sv]
package bpi_pkg;

	// Extra bits over the input sample width for each cubic coefficient and
	// for the Horner accumulator.
	localparam int C1_GROW  = 1;
	localparam int C2_GROW  = 4;
	localparam int C3_GROW  = 3;
	localparam int H_GROW   = 5;
	// Row results carry two more bits than a sample.
	localparam int ROW_GROW = 2;

	typedef struct packed {
		logic not_empty;
		logic full;
	} bpi_qstat_t;

endpackage

[rtl/bpi_coef.sv]
module bpi_coef
	import bpi_pkg::*;
#(
	parameter int W = 18
) (
	input  logic signed [W-1:0]         p0,
	input  logic signed [W-1:0]         p1,
	input  logic signed [W-1:0]         p2,
	input  logic signed [W-1:0]         p3,
	output logic signed [W+C1_GROW-1:0] c1,
	output logic signed [W+C2_GROW-1:0] c2,
	output logic signed [W+C3_GROW-1:0] c3
);

	localparam int C1W = W + C1_GROW;
	localparam int C2W = W + C2_GROW;
	localparam int C3W = W + C3_GROW;

	logic signed [C1W-1:0] a1, e1;
	logic signed [C2W-1:0] a2, b2, e2, d2;
	logic signed [C3W-1:0] a3, b3, e3, d3, diff3;

	always_comb begin
		a1 = C1W'(p0);
		e1 = C1W'(p2);
		a2 = C2W'(p0);
		b2 = C2W'(p1);
		e2 = C2W'(p2);
		d2 = C2W'(p3);
		a3 = C3W'(p0);
		b3 = C3W'(p1);
		e3 = C3W'(p2);
		d3 = C3W'(p3);
		diff3 = b3 - e3;
		c1 = e1 - a1;
		// 2p0 - 5p1 + 4p2 - p3
		c2 = (a2 <<< 1) - ((b2 <<< 2) + b2) + (e2 <<< 2) - d2;
		// 3(p1 - p2) + p3 - p0
		c3 = (diff3 <<< 1) + diff3 + d3 - a3;
	end

endmodule

[rtl/bpi_queue.sv]
module bpi_queue
	import bpi_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output bpi_qstat_t       stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       cnt_q;

	assign stat.not_empty = (cnt_q != 2'd0);
	assign stat.full      = (cnt_q == 2'd2);
	assign rdata          = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.not_empty)
		else $error("queue read while empty");

endmodule

[rtl/bpi_front.sv]
module bpi_front
	import bpi_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16,
	parameter int QW          = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	input  logic signed [SAMPLE_BITS-1:0] sample_c,
	input  logic signed [SAMPLE_BITS-1:0] sample_d,
	input  logic        [FRAC_BITS:0]     frac_v,
	input  logic        [FRAC_BITS:0]     frac_u,
	input  bpi_qstat_t                    qstat,
	output logic                          q_push,
	output logic        [QW-1:0]          q_wdata
);

	localparam int W  = SAMPLE_BITS + ROW_GROW;
	localparam int FW = FRAC_BITS + 1;
	localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

	logic [1:0]                  row_q;
	logic                        last;
	logic [FW-1:0]               v_cl, u_cl;
	logic signed [W-1:0]         p0, p1, p2, p3;
	logic signed [W+C1_GROW-1:0] c1;
	logic signed [W+C2_GROW-1:0] c2;
	logic signed [W+C3_GROW-1:0] c3;

	assign busy   = qstat.full;
	assign q_push = start && !qstat.full;
	assign last   = (row_q == 2'd3);

	// Clamp fractions above one to one.
	assign v_cl = (frac_v > ONE) ? ONE : frac_v;
	assign u_cl = (frac_u > ONE) ? ONE : frac_u;

	assign p0 = W'(sample_a);
	assign p1 = W'(sample_b);
	assign p2 = W'(sample_c);
	assign p3 = W'(sample_d);

	bpi_coef #(.W(W)) u_coef (
		.p0(p0), .p1(p1), .p2(p2), .p3(p3),
		.c1(c1), .c2(c2), .c3(c3)
	);

	assign q_wdata = {c1, c2, c3, p1, v_cl, u_cl, last};

	// Advance the row count on every transfer; it wraps after the fourth row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
		end else if (q_push) begin
			row_q <= row_q + 2'd1;
		end
	end

endmodule

[rtl/bpi_back.sv]
module bpi_back
	import bpi_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16,
	parameter int QW          = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bpi_qstat_t                  qstat,
	input  logic        [QW-1:0]        q_rdata,
	output logic                        q_pop,
	output logic                        done,
	output logic signed [SAMPLE_BITS:0] value
);

	localparam int W   = SAMPLE_BITS + ROW_GROW;
	localparam int OW  = SAMPLE_BITS + 1;
	localparam int FW  = FRAC_BITS + 1;
	localparam int C1W = W + C1_GROW;
	localparam int C2W = W + C2_GROW;
	localparam int C3W = W + C3_GROW;
	localparam int HW  = W + FRAC_BITS + H_GROW;
	localparam int PW  = HW + FW + 1;
	localparam int YW  = HW - FRAC_BITS - 1;
	localparam logic [HW-1:0] HALF = HW'(1) << FRAC_BITS;

	typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_M3, S_FIN, S_COEF} state_t;

	state_t                state_q;
	logic                  pass2_q, last_q;
	logic [1:0]            ridx_q;
	logic signed [OW-1:0]  value_q;
	logic                  done_q;

	logic signed [C1W-1:0] c1_q;
	logic signed [C2W-1:0] c2_q;
	logic signed [C3W-1:0] c3_q;
	logic signed [W-1:0]   p1_q, r_q;
	logic signed [W-1:0]   rows_q [3];
	logic        [FW-1:0]  t_q, u_q;
	logic signed [HW-1:0]  h_q;

	logic signed [C1W-1:0] e_c1, k_c1;
	logic signed [C2W-1:0] e_c2, k_c2;
	logic signed [C3W-1:0] e_c3, k_c3;
	logic signed [W-1:0]   e_p1;
	logic        [FW-1:0]  e_v, e_u;
	logic                  e_last;

	logic signed [HW-1:0]  mul_a, prod_lo, prod_sh, h_next, fin_sum;
	logic signed [PW-1:0]  prod;
	logic signed [YW-1:0]  y;
	logic signed [W-1:0]   row_sat;
	logic signed [OW-1:0]  out_sat;
	logic                  row_fits, out_fits;

	assign {e_c1, e_c2, e_c3, e_p1, e_v, e_u, e_last} = q_rdata;

	// Take the next row as soon as the current cubic is finished, unless the
	// second pass over the kept rows has to follow.
	assign q_pop = qstat.not_empty &&
		((state_q == S_IDLE) || ((state_q == S_FIN) && (pass2_q || !last_q)));

	// Coefficients across the kept rows for the second pass.
	bpi_coef #(.W(W)) u_coef (
		.p0(rows_q[0]), .p1(rows_q[1]), .p2(rows_q[2]), .p3(r_q),
		.c1(k_c1), .c2(k_c2), .c3(k_c3)
	);

	// Shared multiplier: one Horner step per cycle.
	always_comb begin
		mul_a = (state_q == S_M1) ? HW'(c3_q) : h_q;
		prod    = PW'(mul_a) * PW'($signed({1'b0, t_q}));
		prod_lo = prod[HW-1:0];
		prod_sh = prod[FRAC_BITS +: HW];
		case (state_q)
			S_M1:    h_next = (HW'(c2_q) <<< FRAC_BITS) + prod_lo;
			S_M2:    h_next = (HW'(c1_q) <<< FRAC_BITS) + prod_sh;
			default: h_next = prod_sh;
		endcase
		fin_sum  = h_q + (HW'(p1_q) <<< (FRAC_BITS + 1)) + $signed(HALF);
		y        = fin_sum[HW-1:FRAC_BITS+1];
		row_fits = (&y[YW-1:W-1]) || !(|y[YW-1:W-1]);
		out_fits = (&y[YW-1:OW-1]) || !(|y[YW-1:OW-1]);
		row_sat  = row_fits ? y[W-1:0] : {y[YW-1], {(W-1){~y[YW-1]}}};
		out_sat  = out_fits ? y[OW-1:0] : {y[YW-1], {(OW-1){~y[YW-1]}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass2_q <= 1'b0;
			last_q  <= 1'b0;
			ridx_q  <= 2'd0;
			done_q  <= 1'b0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						state_q <= S_M1;
						pass2_q <= 1'b0;
						last_q  <= e_last;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_FIN;
				S_FIN: begin
					if (pass2_q) begin
						value_q <= out_sat;
						done_q  <= 1'b1;
					end else if (last_q) begin
						ridx_q <= 2'd0;
					end else begin
						ridx_q <= ridx_q + 2'd1;
					end
					if (!pass2_q && last_q) begin
						state_q <= S_COEF;
					end else if (q_pop) begin
						state_q <= S_M1;
						pass2_q <= 1'b0;
						last_q  <= e_last;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_COEF: begin
					state_q <= S_M1;
					pass2_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			c1_q <= e_c1;
			c2_q <= e_c2;
			c3_q <= e_c3;
			p1_q <= e_p1;
			t_q  <= e_v;
			u_q  <= e_u;
		end else if (state_q == S_COEF) begin
			c1_q <= k_c1;
			c2_q <= k_c2;
			c3_q <= k_c3;
			p1_q <= rows_q[1];
			t_q  <= u_q;
		end
		if ((state_q == S_M1) || (state_q == S_M2) || (state_q == S_M3)) begin
			h_q <= h_next;
		end
		if ((state_q == S_FIN) && !pass2_q) begin
			if (last_q) r_q <= row_sat;
			else rows_q[ridx_q] <= row_sat;
		end
	end

	assign done  = done_q;
	assign value = value_q;

	a_done_after_pass2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && pass2_q) |=> done_q)
		else $error("patch result not strobed after second pass");
	a_done_only_pass2: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FIN && pass2_q))
		else $error("strobe without a finished second pass");
	a_coef_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COEF) |-> (last_q && !pass2_q && ridx_q == 2'd0))
		else $error("second pass started without a complete patch");

endmodule

[rtl/bicubic_patch_interpolator.sv]
// Catmull-Rom bicubic interpolator over a 4x4 patch, fed one patch row at a time.
// Input: drive sample_a..sample_d, frac_v and frac_u, raise start; a row
// transfers at a rising edge with start high and busy low. Every fourth row
// closes a patch, and only its frac_u is used. Fractions above one clamp to one.
// Front: clamps fractions, classifies the row (last of patch or not) and forms
// the cubic coefficients, then pushes them into a two-entry queue. busy is
// high while that queue is full.
// Back: one shared multiplier runs the three Horner steps (S_M1 to S_M3) plus
// a rounding and saturation step (S_FIN) for each row. After the fourth row it
// forms coefficients across the kept row results (S_COEF) and runs the same
// steps again on the cubic along u. The back takes the next row in S_FIN of
// the current cubic, except after a fourth row's first pass; meanwhile the
// queue keeps accepting rows from the front until it is full.
// Output: value is valid for the single cycle that done is high; the receiver
// cannot stall, so every result is a one-cycle transfer.
// Reset clears the row count, the queue and the sequencer; a partial patch is
// dropped.
module bicubic_patch_interpolator
	import bpi_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	input  logic signed [SAMPLE_BITS-1:0] sample_c,
	input  logic signed [SAMPLE_BITS-1:0] sample_d,
	input  logic        [FRAC_BITS:0]     frac_v,
	input  logic        [FRAC_BITS:0]     frac_u,
	output logic                          done,
	output logic signed [SAMPLE_BITS:0]   value
);

	// Queue entry: three coefficients, the centre sample, both fractions and
	// the last-row flag.
	localparam int W  = SAMPLE_BITS + ROW_GROW;
	localparam int QW = (W + C1_GROW) + (W + C2_GROW) + (W + C3_GROW) + W
		+ 2 * (FRAC_BITS + 1) + 1;

	bpi_qstat_t      qstat;
	logic            q_push, q_pop;
	logic [QW-1:0]   q_wdata, q_rdata;

	bpi_front #(
		.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .QW(QW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.sample_a(sample_a), .sample_b(sample_b),
		.sample_c(sample_c), .sample_d(sample_d),
		.frac_v(frac_v), .frac_u(frac_u),
		.qstat(qstat), .q_push(q_push), .q_wdata(q_wdata)
	);

	// Decouple row intake from the multiplier loop.
	bpi_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata(q_wdata),
		.pop(q_pop), .rdata(q_rdata),
		.stat(qstat)
	);

	bpi_back #(
		.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS), .QW(QW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.qstat(qstat), .q_rdata(q_rdata), .q_pop(q_pop),
		.done(done), .value(value)
	);

endmodule

[dv/bpi_patch_check.sv]
module bpi_patch_check
	import bpi_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	input  logic signed [SAMPLE_BITS-1:0] sample_c,
	input  logic signed [SAMPLE_BITS-1:0] sample_d,
	input  logic        [FRAC_BITS:0]     frac_v,
	input  logic        [FRAC_BITS:0]     frac_u,
	input  logic                          done,
	input  logic signed [SAMPLE_BITS:0]   value,
	output int                            mismatches,
	output int                            pending,
	output int                            rows_seen,
	output int                            values_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     ROW_BITS   = SAMPLE_BITS + ROW_GROW;
	localparam int     OUT_BITS   = SAMPLE_BITS + 1;
	localparam longint FRAC_ONE   = longint'(1) << FRAC_BITS;
	localparam int     PRINT_MAX  = 20;

	int                          fail_count = 0;
	int                          row_total = 0;
	int                          value_total = 0;
	int                          row_idx = 0;
	longint                      kept_rows [3];
	logic signed [SAMPLE_BITS:0] patch_values_due [$];

	function automatic longint clamp_fraction(logic [FRAC_BITS:0] f);
		longint x;
		x = longint'(f);
		return (x > FRAC_ONE) ? FRAC_ONE : x;
	endfunction

	function automatic longint saturate_to(longint x, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// Horner form with FRAC_BITS fraction bits; >>> on longint is a floor shift.
	function automatic longint catmull_rom_fx(longint p0, longint p1, longint p2,
			longint p3, longint t);
		longint c1;
		longint c2;
		longint c3;
		longint h;
		c1 = p2 - p0;
		c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		c3 = 3 * (p1 - p2) + p3 - p0;
		h = c2 * FRAC_ONE + c3 * t;
		h = c1 * FRAC_ONE + ((h * t) >>> FRAC_BITS);
		h = (h * t) >>> FRAC_BITS;
		h = h + p1 * FRAC_ONE * 2 + FRAC_ONE;
		return h >>> (FRAC_BITS + 1);
	endfunction

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= PRINT_MAX)
			$display("%0t ERROR: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		longint                      row_val;
		longint                      patch_val;
		logic signed [SAMPLE_BITS:0] due;
		if (!arst_n) begin
			row_idx = 0;
			patch_values_due.delete();
		end else begin
			// A result can only belong to a patch closed at an earlier edge.
			if (done) begin
				if (patch_values_due.size() == 0) begin
					report_mismatch($sformatf("value %0d with no patch pending", value));
				end else begin
					due = patch_values_due.pop_front();
					value_total++;
					if (value !== due)
						report_mismatch($sformatf("value %0d, predicted %0d", value, due));
				end
			end
			if (start && !busy) begin
				row_total++;
				row_val = saturate_to(catmull_rom_fx(longint'(sample_a), longint'(sample_b),
					longint'(sample_c), longint'(sample_d), clamp_fraction(frac_v)), ROW_BITS);
				if (row_idx < 3) begin
					kept_rows[row_idx] = row_val;
					row_idx++;
				end else begin
					patch_val = saturate_to(catmull_rom_fx(kept_rows[0], kept_rows[1],
						kept_rows[2], row_val, clamp_fraction(frac_u)), OUT_BITS);
					patch_values_due.push_back(patch_val[SAMPLE_BITS:0]);
					row_idx = 0;
				end
			end
		end
		mismatches  <= fail_count;
		pending     <= patch_values_due.size();
		rows_seen   <= row_total;
		values_seen <= value_total;
	end

endmodule

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS    = 16;
	localparam int FRAC_BITS      = 16;
	// Longest stretch without any transfer: sender gaps at 75 percent idle
	// stay far below this, as do the drain pauses and a whole patch in the back.
	localparam int STALL_LIMIT    = 1000;
	localparam int PATCHES_PER_PH = 40;
	localparam int TAIL_CYCLES    = 30;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 16'sh8000;
	localparam logic [FRAC_BITS:0]            F_ONE = 17'h10000;
	localparam logic [FRAC_BITS:0]            F_TOP = 17'h1ffff;
	localparam logic [FRAC_BITS:0]            F_HALF = 17'h08000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_a = '0;
	logic signed [SAMPLE_BITS-1:0] sample_b = '0;
	logic signed [SAMPLE_BITS-1:0] sample_c = '0;
	logic signed [SAMPLE_BITS-1:0] sample_d = '0;
	logic        [FRAC_BITS:0]     frac_v = '0;
	logic        [FRAC_BITS:0]     frac_u = '0;
	logic                          busy;
	logic                          done;
	logic signed [SAMPLE_BITS:0]   value;

	int mismatches;
	int pending;
	int rows_seen;
	int values_seen;
	int idle_pct = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	bicubic_patch_interpolator #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.sample_c(sample_c),
		.sample_d(sample_d),
		.frac_v  (frac_v),
		.frac_u  (frac_u),
		.done    (done),
		.value   (value)
	);

	bpi_patch_check #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.sample_c   (sample_c),
		.sample_d   (sample_d),
		.frac_v     (frac_v),
		.frac_u     (frac_u),
		.done       (done),
		.value      (value),
		.mismatches (mismatches),
		.pending    (pending),
		.rows_seen  (rows_seen),
		.values_seen(values_seen)
	);

	// Sample generators, one style per patch so that some patches are smooth
	// and small while others sit on the rails.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int style);
		case (style)
			0: return SAMPLE_BITS'($urandom);
			1: begin
				case ($urandom_range(3))
					0: return S_MIN;
					1: return S_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			2: return SAMPLE_BITS'($urandom_range(600) - 300);
			default: begin
				// within 255 codes of either rail
				if ($urandom_range(1))
					return S_MAX - SAMPLE_BITS'($urandom_range(255));
				return S_MIN + SAMPLE_BITS'($urandom_range(255));
			end
		endcase
	endfunction

	// Mostly legal fractions, with the ends of the range and out-of-range
	// codes (which must clamp to one) mixed in.
	function automatic logic [FRAC_BITS:0] pick_fraction();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return (FRAC_BITS+1)'($urandom_range(F_ONE));
		if (r < 75)
			return $urandom_range(1) ? F_ONE : '0;
		return (FRAC_BITS+1)'($urandom);
	endfunction

	// Transfer one patch row. Idle the sender at random first, then hold the
	// row on the ports until the block takes it. start is written once per
	// step, so a row that follows directly keeps start high.
	task automatic send_row(input logic signed [SAMPLE_BITS-1:0] a, b, c, d,
			input logic [FRAC_BITS:0] fv, fu);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		sample_a <= a;
		sample_b <= b;
		sample_c <= c;
		sample_d <= d;
		frac_v   <= fv;
		frac_u   <= fu;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and hold off until every predicted patch value has come out.
	// The checker registers its count, so check it only after the next edge.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Watchdog: end the run if nothing transfers for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no transfer for %0d cycles", $realtime, STALL_LIMIT);
				$display("bicubic_patch_interpolator: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int                            phase_pct [4];
		int                            style;
		logic signed [SAMPLE_BITS-1:0] hi;
		logic signed [SAMPLE_BITS-1:0] lo;
		logic [FRAC_BITS:0]            fu;

		// The receiver cannot stall results; two phases run the sender flat
		// out and the other two idle the sender.
		phase_pct = '{0, 75, 0, 38};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed patches, sender flat out.
		// Flat zero patch at both fraction ends of zero.
		repeat (4)
			send_row('0, '0, '0, '0, '0, '0);
		// Flat patch on the upper rail, fractions exactly one.
		repeat (4)
			send_row(S_MAX, S_MAX, S_MAX, S_MAX, F_ONE, F_ONE);
		// Flat patch on the lower rail, fractions above one clamp to one.
		for (int r = 0; r < 4; r++)
			send_row(S_MIN, S_MIN, S_MIN, S_MIN, F_TOP, (r == 3) ? 17'h10001 : F_TOP);
		// Steps rail to rail in both directions: largest overshoot of the cubic,
		// pushing row and patch values past the sample range.
		for (int r = 0; r < 4; r++) begin
			if (r == 0 || r == 3)
				send_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, F_HALF);
			else
				send_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, F_TOP);
		end
		// Alternating bit patterns, smallest and largest fractions below one.
		for (int r = 0; r < 4; r++)
			send_row(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
				(r % 2) ? 17'h0ffff : 17'h00001, 17'h00001);
		// Ramp rows; frac_u on rows one to three is junk and must be ignored.
		for (int r = 0; r < 4; r++)
			send_row(16'(r * 1000 - 2000), 16'(r * 1000 - 1000), 16'(r * 1000),
				16'(r * 1000 + 1000), 17'(r * 20000 + 1), (r == 3) ? 17'h0ffff : pick_fraction());

		// Hold the sender until the block is empty once.
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			for (int p = 0; p < PATCHES_PER_PH; p++) begin
				// Now and then run a whole patch without idling.
				idle_pct = ($urandom_range(4) == 0) ? 0 : phase_pct[ph];
				style = $urandom_range(3);
				for (int r = 0; r < 4; r++) begin
					fu = pick_fraction();
					send_row(pick_sample(style), pick_sample(style), pick_sample(style),
						pick_sample(style), pick_fraction(), fu);
				end
				// Mix rail patches into smooth ones to excite overshoot.
				if (style == 2 && $urandom_range(3) == 0) begin
					hi = S_MAX;
					lo = S_MIN;
					for (int r = 0; r < 4; r++)
						send_row(lo, hi, hi, lo, pick_fraction(), pick_fraction());
				end
			end
			wait_drained();
		end

		idle_pct = 0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d patch rows and compared %0d patch values; sender idle 0, 38 and 75",
			rows_seen, values_seen);
		$display("percent, rail, clamp and overshoot patches, with drain pauses between phases.");
		if (mismatches == 0 && pending == 0)
			$display("bicubic_patch_interpolator: match");
		else
			$display("bicubic_patch_interpolator: mismatch");
		$finish;
	end

endmodule
